// File: src/srbe_pkg.sv
// Shared types and constants of the shaper rate and burst encoder.
package srbe_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 40;
  localparam int unsigned EXP_W  = 4;
  localparam int unsigned MANT_W = 8;
  // Product (base times the sum of 256 and mantissa), and compare limit
  localparam int unsigned PROD_W = 40;
  localparam int unsigned LIM_W  = 64;
  localparam int unsigned SH_W   = 5;
  localparam int unsigned CFG_W  = 2;

  localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;

  typedef enum logic {
    FUNC_RATE  = 1'b0,
    FUNC_BURST = 1'b1
  } srbe_func_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_MIN_RATE  = 2'd0,
    CFG_MAX_RATE  = 2'd1,
    CFG_MIN_BURST = 2'd2,
    CFG_MAX_BURST = 2'd3
  } srbe_cfg_e;

  // One word in flight through the mantissa search
  typedef struct packed {
    srbe_func_e              func;
    logic                    fail;
    logic [EXP_W-1:0]        e;
    logic [EXP_W-1:0]        d;
    logic [MANT_W-1:0]       m;
    logic [PROD_W-1:0]       prod;
    logic [LIM_W-1:0]        limit;
    logic [SH_W-1:0]         shl;
    logic [SH_W-1:0]         shr;
  } srbe_item_t;

endpackage

// File: src/srbe_mant_step.sv
// One bit of the mantissa search, with its pipeline register.
module srbe_mant_step import srbe_pkg::*; #(
  parameter int unsigned BIT       = 7,
  parameter int unsigned RATE_BASE = 2000000,
  parameter int unsigned MANT_MAX  = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  srbe_item_t item_i,
  output logic       valid_o,
  input  logic       ready_i,
  output srbe_item_t item_o
);

  localparam logic [PROD_W-1:0] RATE_INC  = PROD_W'(64'(RATE_BASE) << BIT);
  localparam logic [PROD_W-1:0] BURST_INC = PROD_W'(64'(1) << BIT);

  logic [MANT_W:0]   trial_m;
  logic [PROD_W-1:0] trial_p;
  logic              take;
  srbe_item_t        item_d, item_q;
  logic              valid_q;

  // Try setting this bit: keep it if the mantissa stays within MANT_MAX and the encoded value still fits the request
  always_comb begin
    trial_m = {1'b0, item_i.m} | ((MANT_W+1)'(1) << BIT);
    trial_p = item_i.prod + ((item_i.func == FUNC_BURST) ? BURST_INC : RATE_INC);
    take    = (trial_m <= (MANT_W+1)'(MANT_MAX)) && (LIM_W'(trial_p) <= item_i.limit);
    item_d  = item_i;
    if (take) begin
      item_d.m    = trial_m[MANT_W-1:0];
      item_d.prod = trial_p;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Advance valid when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load the word
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/shaper_rate_burst_encoder_unit.sv
// Top level of the shaper rate and burst size encoder.
//
// Converts a requested shaper rate (func 0) or burst size (func 1) into
// exponent, mantissa and divider exponent fields plus the truncated value they
// encode, failing with all zeros outside the configured range or below the
// lowest threshold. The pipeline takes one word per cycle unless stalled:
// one stage of range and threshold compares, one stage that picks the
// exponents, one stage that builds the compare limit, eight mantissa bit
// stages (each an add and a 64-bit compare) and the output register. Stalls
// hold each stage in place; empty stages still take words while the output
// waits. Configuration writes are taken at any cycle with no wait.
module shaper_rate_burst_encoder_unit import srbe_pkg::*; #(
  parameter int unsigned RATE_BASE     = 2000000,
  parameter int unsigned RATE_EXP_MAX  = 15,
  parameter int unsigned RATE_DIV_MAX  = 15,
  parameter int unsigned MANT_MAX      = 255,
  parameter int unsigned BURST_EXP_MAX = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_index_i,
  input  logic [VAL_W-1:0]  cfg_data_i,
  // request
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [VAL_W-1:0]  value_i,
  // result
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ok_o,
  output logic [VAL_W-1:0]  real_value_o,
  output logic [EXP_W-1:0]  exponent_o,
  output logic [MANT_W-1:0] mantissa_o,
  output logic [EXP_W-1:0]  div_exp_o
);

  localparam int unsigned NSTEP = MANT_W;

  // ---------------- configuration registers
  logic [VAL_W-1:0] min_rate_q, max_rate_q, min_burst_q, max_burst_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q  <= VAL_W'(64'd61);
      max_rate_q  <= VAL_W'(64'd130816000000);
      min_burst_q <= VAL_W'(64'd2);
      max_burst_q <= VAL_W'(64'd130816);
    end else if (cfg_valid_i) begin
      unique case (srbe_cfg_e'(cfg_index_i))
        CFG_MIN_RATE:  min_rate_q  <= cfg_data_i;
        CFG_MAX_RATE:  max_rate_q  <= cfg_data_i;
        CFG_MIN_BURST: min_burst_q <= cfg_data_i;
        CFG_MAX_BURST: max_burst_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage A: range and threshold compares
  logic                      ready_a, valid_a_q;
  srbe_func_e                func_a_q;
  logic [VAL_W-1:0]          value_a_q;
  logic                      rate_in_a_d, rate_in_a_q;
  logic                      burst_in_a_d, burst_in_a_q;
  logic                      le_base_a_d, le_base_a_q;
  logic [RATE_DIV_MAX:0]     ge_d_a_d, ge_d_a_q;
  logic [RATE_EXP_MAX:0]     ge_e_a_d, ge_e_a_q;
  logic [BURST_EXP_MAX:0]    ge_b_a_d, ge_b_a_q;

  // Compare the request against the range and the constant exponent thresholds
  always_comb begin
    rate_in_a_d  = (value_i >= min_rate_q) && (value_i <= max_rate_q);
    burst_in_a_d = (value_i >= min_burst_q) && (value_i <= max_burst_q);
    le_base_a_d  = 64'(value_i) <= 64'(RATE_BASE);
    for (int k = 0; k <= int'(RATE_DIV_MAX); k++) begin
      ge_d_a_d[k] = 64'(value_i) >= (64'(RATE_BASE) >> k);
    end
    for (int k = 0; k <= int'(RATE_EXP_MAX); k++) begin
      ge_e_a_d[k] = 64'(value_i) >= (64'(RATE_BASE) << k);
    end
    for (int k = 0; k <= int'(BURST_EXP_MAX); k++) begin
      ge_b_a_d[k] = 64'(value_i) >= (64'(2) << k);
    end
  end

  logic ready_b, valid_b_q;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_stall_o = !ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (ready_a) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      func_a_q     <= srbe_func_e'(func_i);
      value_a_q    <= value_i;
      rate_in_a_q  <= rate_in_a_d;
      burst_in_a_q <= burst_in_a_d;
      le_base_a_q  <= le_base_a_d;
      ge_d_a_q     <= ge_d_a_d;
      ge_e_a_q     <= ge_e_a_d;
      ge_b_a_q     <= ge_b_a_d;
    end
  end

  // ---------------- stage B: pick exponents and starting product
  srbe_item_t item_b_d, item_b_q;
  logic [EXP_W-1:0] e_b, d_b;

  always_comb begin
    e_b = '0;
    d_b = '0;
    item_b_d       = '0;
    item_b_d.func  = func_a_q;
    item_b_d.limit = LIM_W'(value_a_q) + LIM_W'(1);
    if (func_a_q == FUNC_RATE) begin
      if (le_base_a_q) begin
        // smallest divider exponent whose threshold the request reaches
        for (int k = int'(RATE_DIV_MAX); k >= 0; k--) begin
          if (ge_d_a_q[k]) d_b = EXP_W'(k);
        end
      end else begin
        // largest exponent whose threshold the request reaches
        for (int k = 1; k <= int'(RATE_EXP_MAX); k++) begin
          if (ge_e_a_q[k]) e_b = EXP_W'(k);
        end
      end
      item_b_d.fail = !rate_in_a_q || (le_base_a_q && !ge_d_a_q[RATE_DIV_MAX]);
      item_b_d.prod = PROD_W'(64'(RATE_BASE) << 8);
      item_b_d.shl  = SH_W'(e_b);
      item_b_d.shr  = SH_W'(d_b) + SH_W'(8);
    end else begin
      for (int k = 1; k <= int'(BURST_EXP_MAX); k++) begin
        if (ge_b_a_q[k]) e_b = EXP_W'(k);
      end
      item_b_d.fail = !burst_in_a_q || !ge_b_a_q[0];
      item_b_d.prod = PROD_W'(256);
      item_b_d.shl  = SH_W'(e_b) + SH_W'(1);
      item_b_d.shr  = SH_W'(8);
    end
    item_b_d.e = e_b;
    item_b_d.d = d_b;
  end

  logic ready_c, valid_c_q;
  assign ready_b = !valid_b_q || ready_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (ready_b) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_a_q) begin
      item_b_q <= item_b_d;
    end
  end

  // ---------------- stage C: largest product that still fits the request
  srbe_item_t item_c_d, item_c_q;

  always_comb begin
    item_c_d       = item_b_q;
    item_c_d.limit = ((item_b_q.limit << item_b_q.shr) - LIM_W'(1)) >> item_b_q.shl;
  end

  logic [NSTEP:0] step_valid, step_ready;
  srbe_item_t     step_item [NSTEP+1];

  assign ready_c = !valid_c_q || step_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else if (ready_c) begin
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && valid_b_q) begin
      item_c_q <= item_c_d;
    end
  end

  // ---------------- mantissa search, most significant bit first
  assign step_valid[0] = valid_c_q;
  assign step_item[0]  = item_c_q;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    srbe_mant_step #(
      .BIT       (NSTEP - 1 - g),
      .RATE_BASE (RATE_BASE),
      .MANT_MAX  (MANT_MAX)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (step_valid[g]),
      .ready_o (step_ready[g]),
      .item_i  (step_item[g]),
      .valid_o (step_valid[g+1]),
      .ready_i (step_ready[g+1]),
      .item_o  (step_item[g+1])
    );
  end

  // ---------------- output stage: encoded value, zeros on failure
  srbe_item_t       item_f;
  logic [LIM_W-1:0] wide_f;
  logic [VAL_W-1:0] real_f;
  logic             out_valid_q;
  logic             ok_q;
  logic [VAL_W-1:0] real_q;
  logic [EXP_W-1:0] exp_q, dexp_q;
  logic [MANT_W-1:0] mant_q;

  assign item_f = step_item[NSTEP];

  always_comb begin
    wide_f = (LIM_W'(item_f.prod) << item_f.shl) >> item_f.shr;
    real_f = (wide_f > LIM_W'(VAL_ALL_ONES)) ? VAL_ALL_ONES : wide_f[VAL_W-1:0];
  end

  assign step_ready[NSTEP] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_ready[NSTEP]) begin
      out_valid_q <= step_valid[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_ready[NSTEP] && step_valid[NSTEP]) begin
      ok_q   <= !item_f.fail;
      real_q <= item_f.fail ? '0 : real_f;
      exp_q  <= item_f.fail ? '0 : item_f.e;
      mant_q <= item_f.fail ? '0 : item_f.m;
      dexp_q <= item_f.fail ? '0 : item_f.d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign real_value_o = real_q;
  assign exponent_o   = exp_q;
  assign mantissa_o   = mant_q;
  assign div_exp_o    = dexp_q;

endmodule

// File: src/srbe_checker.sv
// Port-level checks of the shaper rate and burst encoder, bound to the top level.
module srbe_checker import srbe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              ok_o,
  input logic [VAL_W-1:0]  real_value_o,
  input logic [EXP_W-1:0]  exponent_o,
  input logic [MANT_W-1:0] mantissa_o,
  input logic [EXP_W-1:0]  div_exp_o
);

  // A failed conversion carries all-zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |->
      (real_value_o == '0 && exponent_o == '0 && mantissa_o == '0 && div_exp_o == '0))
    else $error("failed conversion with nonzero fields");

  // Divider and exponent branches never mix
  a_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_o && div_exp_o != '0) |-> (exponent_o == '0))
    else $error("divider exponent and exponent both set");

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(ok_o) && $stable(real_value_o) && $stable(exponent_o)
       && $stable(mantissa_o) && $stable(div_exp_o)))
    else $error("stalled result word changed");

endmodule

bind shaper_rate_burst_encoder_unit srbe_checker u_srbe_checker (.*);
